FILE: rtl/core/hash_join_build_probe_core_assert.svh
// assertion macros for the hash-join core checker
// expects clk and rst_n in the scope where a macro is used
`ifndef HASH_JOIN_BUILD_PROBE_CORE_ASSERT_SVH
`define HASH_JOIN_BUILD_PROBE_CORE_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define HJB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash join core assertion failed");

// consequence must hold in the cycle after the antecedent
`define HJB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash join core assertion failed");

`endif

FILE: rtl/core/hjb_pkg.sv
// shared types and constants of the hash-join build and probe core
// no dependencies
`default_nettype none

package hjb_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 64;
    localparam int CFG_W    = 5;
    localparam int STATUS_W = 3;

    localparam int SLOTS_LOG2_RESET = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROBE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 3'd0,
        ST_HIT  = 3'd1,
        ST_MISS = 3'd2,
        ST_FULL = 3'd3,
        ST_ZERO = 3'd4
    } status_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_PROBE  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_NOP    = 3'd3,
        OP_ZERO   = 3'd4
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             last;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/hjb_channels.sv
// request and result channel interfaces of the hash-join core
// depends on hjb_pkg
`default_nettype none

interface hjb_req_if import hjb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last_of_batch;

    modport source (output valid, output cmd, output key, output value,
                    output last_of_batch, input ready);
    modport sink   (input valid, input cmd, input key, input value,
                    input last_of_batch, output ready);
endinterface

interface hjb_rsp_if import hjb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    stored_value;
    logic [SUM_W-1:0]    checksum;

    modport source (output valid, output status, output stored_value,
                    output checksum, input ready);
    modport sink   (input valid, input status, input stored_value,
                    input checksum, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hjb_queue.sv
// two-entry queue of classified requests between front and back
// depends on hjb_pkg
`default_nettype none

module hjb_queue import hjb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       empty
);

    localparam int DEPTH = 2;

    item_t      entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hjb_front.sv
// front end: takes requests, classifies them, holds the slot count register
// depends on hjb_pkg and hjb_channels
`default_nettype none

module hjb_front import hjb_pkg::*;
#(
    parameter int MAX_SLOT_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    hjb_req_if.sink                       request,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_W-1:0]         cfg_wdata,
    input  wire logic                     init_busy,
    input  wire logic                     q_full,
    output logic                          push,
    output item_t                         push_item,
    output logic [MAX_SLOT_BITS-1:0]      slot_mask
);

    localparam int RESET_BITS = (SLOTS_LOG2_RESET > MAX_SLOT_BITS) ?
                                MAX_SLOT_BITS : SLOTS_LOG2_RESET;
    localparam logic [MAX_SLOT_BITS-1:0] MASK_RESET =
        MAX_SLOT_BITS'((2 ** RESET_BITS) - 1);

    logic [MAX_SLOT_BITS-1:0] slot_mask_reg, slot_mask_next;
    logic [CFG_W-1:0]         used_bits;
    op_t                      op;

    // clamp the written slot count to 1..MAX_SLOT_BITS and expand to a mask
    always_comb
    begin
        used_bits = cfg_wdata;
        if (cfg_wdata == '0)
        begin
            used_bits = CFG_W'(1);
        end
        else if (cfg_wdata > CFG_W'(MAX_SLOT_BITS))
        begin
            used_bits = CFG_W'(MAX_SLOT_BITS);
        end
        for (int i = 0; i < MAX_SLOT_BITS; i++)
        begin
            slot_mask_next[i] = (CFG_W'(i) < used_bits);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            slot_mask_reg <= slot_mask_next;
        end
    end

    assign slot_mask = slot_mask_reg;

    always_comb
    begin
        case (request.cmd)
            CMD_INSERT: op = OP_INSERT;
            CMD_PROBE:  op = OP_PROBE;
            CMD_CLEAR:  op = OP_CLEAR;
            default:    op = OP_NOP;
        endcase
        // key zero is the empty marker and never enters the table
        if ((request.cmd inside {CMD_INSERT, CMD_PROBE}) && (request.key == '0))
        begin
            op = OP_ZERO;
        end
    end

    assign request.ready   = !q_full && !init_busy;
    assign push            = request.valid && request.ready;
    assign push_item.op    = op;
    assign push_item.key   = request.key;
    assign push_item.value = request.value;
    assign push_item.last  = request.last_of_batch;

endmodule

`default_nettype wire

FILE: rtl/core/hjb_back.sv
// back end: table memory, linear-probe sequencer, checksum and result register
// depends on hjb_pkg and hjb_channels
`default_nettype none

module hjb_back import hjb_pkg::*;
#(
    parameter int MAX_SLOT_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     empty,
    input  wire item_t                    pop_item,
    output logic                          pop,
    input  wire logic [MAX_SLOT_BITS-1:0] slot_mask,
    output logic                          init_busy,
    hjb_rsp_if.source                     result
);

    localparam int DEPTH = 2 ** MAX_SLOT_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_CHECK = 5'b00100,
        S_CLEAR = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_val_reg;

    state_t                   state_reg, state_next;
    logic                     init_reg, init_next;
    logic [MAX_SLOT_BITS-1:0] addr_reg, addr_next;
    logic [MAX_SLOT_BITS-1:0] cnt_reg, cnt_next;
    op_t                      op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [VAL_W-1:0]         value_reg, value_next;
    logic                     last_reg, last_next;
    status_t                  status_reg, status_next;
    logic [VAL_W-1:0]         found_reg, found_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [VAL_W-1:0]         out_stored_reg, out_stored_next;
    logic [SUM_W-1:0]         out_sum_reg, out_sum_next;

    logic             key_we;
    logic             val_we;
    logic [KEY_W-1:0] wkey;

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_stored_next = out_stored_reg;
        out_sum_next    = out_sum_reg;
        pop             = 1'b0;
        key_we          = 1'b0;
        val_we          = 1'b0;
        wkey            = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    op_next    = pop_item.op;
                    key_next   = pop_item.key;
                    value_next = pop_item.value;
                    last_next  = pop_item.last;
                    found_next = '0;
                    cnt_next   = '0;
                    addr_next  = pop_item.key[MAX_SLOT_BITS-1:0] & slot_mask;
                    case (pop_item.op)
                        OP_INSERT, OP_PROBE:
                        begin
                            state_next = S_LOOK;
                        end
                        OP_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = S_CLEAR;
                        end
                        OP_ZERO:
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_FIN;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end

            // slot read in flight
            S_LOOK:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if ((op_reg == OP_INSERT) && (rd_key_reg == '0))
                begin
                    key_we      = 1'b1;
                    val_we      = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_FIN;
                end
                else if ((op_reg == OP_PROBE) && (rd_key_reg == key_reg))
                begin
                    found_next  = rd_val_reg;
                    sum_next    = sum_reg + SUM_W'({1'b0, value_reg} + {1'b0, rd_val_reg});
                    status_next = ST_HIT;
                    state_next  = S_FIN;
                end
                else if ((op_reg == OP_PROBE) && (rd_key_reg == '0))
                begin
                    status_next = ST_MISS;
                    state_next  = S_FIN;
                end
                else if (cnt_reg == slot_mask)
                begin
                    // every slot in use visited
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    addr_next  = (addr_reg + 1'b1) & slot_mask;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_LOOK;
                end
            end

            // sweep of the whole key store, also run once after reset
            S_CLEAR:
            begin
                key_we = 1'b1;
                wkey   = '0;
                if (addr_reg == '1)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        state_next  = S_FIN;
                    end
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_stored_next = found_reg;
                    out_sum_next    = sum_reg;
                    if (last_reg)
                    begin
                        sum_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            addr_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            addr_reg      <= addr_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_stored_reg <= out_stored_next;
        out_sum_reg    <= out_sum_next;
    end

    // single-port table, read data registered
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[addr_reg] <= wkey;
        end
        if (val_we)
        begin
            val_mem[addr_reg] <= value_reg;
        end
        rd_key_reg <= key_mem[addr_reg];
        rd_val_reg <= val_mem[addr_reg];
    end

    assign init_busy           = init_reg;
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.stored_value = out_stored_reg;
    assign result.checksum     = out_sum_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hash_join_build_probe_core.sv
// hash-join build and probe core: front end, request queue and probe back end
// depends on hjb_pkg, hjb_channels, hjb_front, hjb_queue and hjb_back
//
// request channel carries cmd (insert, probe, clear), key, value and
// last_of_batch; every request gives exactly one result with status,
// stored_value and the running checksum after that request.
// slot count is set through cfg_we / cfg_wdata (log2 of slots); the user
// must do so only while idle, the block itself does not enforce it.
// insert and probe walk the table from the home slot, each slot visited
// with a read of the single-port table (S_LOOK), then a compare (S_CHECK);
// the result is registered from S_FIN; key-zero and unused commands go
// from S_IDLE straight to S_FIN. clear sweeps all 2**MAX_SLOT_BITS slots,
// one per cycle. after reset the same sweep runs with request.ready low;
// the checksum starts at zero.
// a stalled result is held in the output register; meanwhile the back end
// finishes one more request and holds it, the queue takes two more, then
// request.ready drops.
`default_nettype none

module hash_join_build_probe_core import hjb_pkg::*;
#(
    parameter int MAX_SLOT_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    hjb_req_if.sink               request,
    hjb_rsp_if.source             result,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic                     init_busy;
    logic                     q_full;
    logic                     q_empty;
    logic                     push;
    logic                     pop;
    item_t                    push_item;
    item_t                    pop_item;
    logic [MAX_SLOT_BITS-1:0] slot_mask;

    hjb_front #(
        .MAX_SLOT_BITS (MAX_SLOT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .init_busy (init_busy),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .slot_mask (slot_mask)
    );

    hjb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    hjb_back #(
        .MAX_SLOT_BITS (MAX_SLOT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .slot_mask (slot_mask),
        .init_busy (init_busy),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hjb_checker.sv
// port-level checks of the hash-join core, bound to the top level
// depends on hjb_pkg and hash_join_build_probe_core_assert.svh
`default_nettype none

`include "hash_join_build_probe_core_assert.svh"

module hjb_checker import hjb_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] rsp_status,
    input wire logic [VAL_W-1:0]    rsp_stored_value,
    input wire logic [SUM_W-1:0]    rsp_checksum
);

    logic [STATUS_W+VAL_W+SUM_W-1:0] rsp_payload;
    assign rsp_payload = {rsp_status, rsp_stored_value, rsp_checksum};

    `HJB_ASSERT_NEXT(a_rsp_valid_held, rsp_valid && !rsp_ready, rsp_valid)
    `HJB_ASSERT_NEXT(a_rsp_payload_held, rsp_valid && !rsp_ready, $stable(rsp_payload))
    // only a hit returns a stored value
    `HJB_ASSERT_NOW(a_value_only_on_hit, rsp_valid && (rsp_stored_value != '0), rsp_status == ST_HIT)
    // table sweep after reset keeps both channels quiet
    `HJB_ASSERT_NEXT(a_quiet_after_reset, $rose(rst_n), !req_ready && !rsp_valid)

endmodule

bind hash_join_build_probe_core hjb_checker u_hjb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (request.ready),
    .rsp_valid        (result.valid),
    .rsp_ready        (result.ready),
    .rsp_status       (result.status),
    .rsp_stored_value (result.stored_value),
    .rsp_checksum     (result.checksum)
);

`default_nettype wire
